// ===== design/crst_pkg.sv =====
`default_nettype none
package crst_pkg;

  // Table geometry.
  localparam int SLOTS  = 64;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_W  = $clog2(SLOTS + 1);

  // Configuration register map and reset value.
  localparam int          REG_RETRY_LIMIT   = 0;
  localparam logic [3:0]  RETRY_LIMIT_RESET = 4'd5;

  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_SERVICE = 2'd1,
    REQ_REPORT  = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_NONE    = 3'd2,
    ST_ISSUED  = 3'd3,
    ST_REPORT  = 3'd4
  } status_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [7:0]  cmd_byte;
    logic [7:0]  value_byte;
    logic [5:0]  report_slot;
    logic        write_ok;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  issued_cmd;
    logic [7:0]  issued_value;
    logic [5:0]  issued_slot;
    logic [6:0]  given_up_count;
  } res_t;

  // One slot's stored contents.
  typedef struct packed {
    logic [7:0]  cmd;
    logic [7:0]  value;
    logic [3:0]  retries;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ===== design/command_retry_slot_table_core.sv =====
// Push: stores into the lowest free slot, found by scanning the pending flags upward.
// Service: scans the slot memory one slot per cycle, stopping at the first issue;
// report and unused requests go straight to the result.
// One request is worked at a time; the next beat can be taken once the result is out.
// Reset (rst, synchronous, active high) clears all pending flags at once and sets
// retry_limit to 5; slot contents need no clearing pass.
`default_nettype none
module command_retry_slot_table_core import crst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire req_t        in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output res_t             out_data
);

  logic [3:0] retry_limit;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (int'(paddr[2:2]) == REG_RETRY_LIMIT);

  // Configuration register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= RETRY_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      retry_limit <= pwdata[3:0];
    end
  end

  // Register readback.
  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {28'd0, retry_limit};
    end
  end

  crst_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .retry_limit (retry_limit),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire

// ===== design/crst_ram.sv =====
`default_nettype none
module crst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/crst_engine.sv =====
`default_nettype none
module crst_engine import crst_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [3:0] retry_limit,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire req_t       in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output res_t            out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_SVC,
    S_RESULT
  } state_t;

  state_t             state, state_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic               chk_vld, chk_vld_next;
  logic [SLOT_W-1:0]  chk_idx, chk_idx_next;
  logic [6:0]         gave, gave_next;
  logic [SLOTS-1:0]   pending, pending_next;
  logic [7:0]         cmd, cmd_next;
  logic [7:0]         value, value_next;
  res_t               res, res_next;
  logic               out_valid_next;
  res_t               out_data_next;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  entry_t             ram_wdata;
  logic [SLOT_W-1:0]  cur;
  entry_t             ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;

  assign cur       = idx[SLOT_W-1:0];
  assign ram_rdata = entry_t'(ram_rbits);
  assign in_stall  = (state != S_IDLE);

  crst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur),
    .rdata (ram_rbits)
  );

  // Sequencer: push scans the pending flags, service scans the slot memory
  // with the read of one slot overlapping the check of the previous one.
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    chk_vld_next   = chk_vld;
    chk_idx_next   = chk_idx;
    gave_next      = gave;
    pending_next   = pending;
    cmd_next       = cmd;
    value_next     = value;
    res_next       = res;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    ram_we         = 1'b0;
    ram_waddr      = cur;
    ram_wdata      = '0;

    // The output beat leaves when it is taken.
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          idx_next     = '0;
          chk_vld_next = 1'b0;
          gave_next    = '0;
          cmd_next     = in_data.cmd_byte;
          value_next   = in_data.value_byte;
          res_next     = '{status: ST_NONE, default: '0};
          case (in_data.req_type)
            REQ_PUSH:    state_next = S_PUSH;
            REQ_SERVICE: state_next = S_SVC;
            REQ_REPORT: begin
              if (in_data.write_ok && (int'(in_data.report_slot) < SLOTS)) begin
                pending_next[SLOT_W'(in_data.report_slot)] = 1'b0;
              end
              res_next.status = ST_REPORT;
              state_next      = S_RESULT;
            end
            default: state_next = S_RESULT;
          endcase
        end
      end

      S_PUSH: begin
        if (!pending[cur]) begin
          ram_we             = 1'b1;
          ram_waddr          = cur;
          ram_wdata          = '{cmd: cmd, value: value, retries: 4'd0};
          pending_next[cur]  = 1'b1;
          res_next.status      = ST_STORED;
          res_next.issued_slot = 6'(cur);
          state_next         = S_RESULT;
        end else if (int'(cur) == SLOTS - 1) begin
          res_next.status = ST_FULL;
          state_next      = S_RESULT;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      S_SVC: begin
        // Read side: fetch the next slot while one is left.
        if (int'(idx) < SLOTS) begin
          idx_next     = idx + 1'b1;
          chk_vld_next = 1'b1;
          chk_idx_next = cur;
        end else begin
          chk_vld_next = 1'b0;
        end
        // Check side: act on the slot fetched in the previous cycle.
        if (chk_vld) begin
          if (pending[chk_idx] && (ram_rdata.retries < retry_limit)) begin
            ram_we    = 1'b1;
            ram_waddr = chk_idx;
            ram_wdata = '{cmd: ram_rdata.cmd, value: ram_rdata.value,
                          retries: ram_rdata.retries + 4'd1};
            res_next  = '{status: ST_ISSUED, issued_cmd: ram_rdata.cmd,
                          issued_value: ram_rdata.value,
                          issued_slot: 6'(chk_idx), given_up_count: gave};
            state_next = S_RESULT;
          end else begin
            if (pending[chk_idx]) begin
              pending_next[chk_idx] = 1'b0;
              gave_next = gave + 7'd1;
            end
            if (int'(chk_idx) == SLOTS - 1) begin
              res_next = '{status: ST_NONE, given_up_count: gave_next, default: '0};
              state_next = S_RESULT;
            end
          end
        end
      end

      S_RESULT: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          out_data_next  = res;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // State, flags and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pending   <= '0;
      out_valid <= 1'b0;
      chk_vld   <= 1'b0;
    end else begin
      state     <= state_next;
      pending   <= pending_next;
      out_valid <= out_valid_next;
      chk_vld   <= chk_vld_next;
    end
    idx      <= idx_next;
    chk_idx  <= chk_idx_next;
    gave     <= gave_next;
    cmd      <= cmd_next;
    value    <= value_next;
    res      <= res_next;
    out_data <= out_data_next;
  end

endmodule
`default_nettype wire

// ===== design/crst_checker.sv =====
`default_nettype none
module crst_checker import crst_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire res_t out_data
);

  // A stalled result beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed under stall");

  // A taken request keeps the input stalled while it is worked.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in progress");

  // A stored entry reports no issued bytes and no abandoned entries.
  a_stored: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_STORED) |->
      (out_data.issued_cmd == 8'd0) && (out_data.given_up_count == 7'd0))
    else $error("stored result carries issue fields");

  // Only an issue or a store names a slot.
  a_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_NONE || out_data.status == ST_FULL ||
                  out_data.status == ST_REPORT) |-> (out_data.issued_slot == 6'd0))
    else $error("slot reported without an issue or store");

endmodule

bind command_retry_slot_table_core crst_checker u_crst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
